>>> hdl/vector2d_fixed_point_alu_core_macros.svh
// Assertion macros shared by the vector ALU core.
`ifndef VECTOR2D_FIXED_POINT_ALU_CORE_MACROS_SVH
`define VECTOR2D_FIXED_POINT_ALU_CORE_MACROS_SVH

// Check a consequence in the same cycle as its cause.
`define VADU_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("vector ALU core: same-cycle check failed");

// Check a consequence in the cycle after its cause.
`define VADU_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("vector ALU core: next-cycle check failed");

`endif

>>> hdl/vadu_pkg.sv
// Shared types, constants and helper functions of the vector ALU core.
package vadu_pkg;

    localparam int DATA_W    = 32;
    localparam int FRAC_BITS = 16;
    localparam int DW        = DATA_W + FRAC_BITS;
    localparam int SQ_W      = 2 * DATA_W;
    localparam int ROOT_W    = SQ_W / 2;
    localparam int WIDE      = 2 * DATA_W + 2;
    localparam int BIT_POS_W = $clog2(ROOT_W);

    localparam logic [3:0] ACT_ADD_V  = 4'd0;
    localparam logic [3:0] ACT_SUB_V  = 4'd1;
    localparam logic [3:0] ACT_MUL_V  = 4'd2;
    localparam logic [3:0] ACT_DIV_V  = 4'd3;
    localparam logic [3:0] ACT_ADD_S  = 4'd4;
    localparam logic [3:0] ACT_SUB_S  = 4'd5;
    localparam logic [3:0] ACT_MUL_S  = 4'd6;
    localparam logic [3:0] ACT_DIV_S  = 4'd7;
    localparam logic [3:0] ACT_SQDIST = 4'd8;
    localparam logic [3:0] ACT_MAG    = 4'd9;
    localparam logic [3:0] ACT_SQMAG  = 4'd10;
    localparam logic [3:0] ACT_NORM   = 4'd11;

    localparam logic signed [DATA_W-1:0] SMAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] SMIN = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic signed [WIDE-1:0] SMAX_WIDE = WIDE'(SMAX);
    localparam logic signed [WIDE-1:0] SMIN_WIDE = WIDE'(SMIN);

    typedef struct packed {
        logic [3:0]               act;
        logic signed [DATA_W-1:0] ax;
        logic signed [DATA_W-1:0] ay;
        logic signed [DATA_W-1:0] bx;
        logic signed [DATA_W-1:0] by;
        logic signed [DATA_W-1:0] sc;
    } in_t;

    typedef struct packed {
        logic [3:0]               act;
        logic signed [DATA_W-1:0] ax;
        logic signed [DATA_W-1:0] ay;
        logic signed [DATA_W-1:0] ox;
        logic signed [DATA_W-1:0] oy;
        logic signed [DATA_W-1:0] rx;
        logic signed [DATA_W-1:0] ry;
        logic signed [DATA_W-1:0] rs;
        logic                     ov;
        logic [SQ_W-1:0]          sq;
    } item_t;

    typedef struct packed {
        item_t           item;
        logic [SQ_W-1:0] rem;
        logic [SQ_W-1:0] root;
    } sqrt_t;

    typedef struct packed {
        logic [DATA_W-1:0] rem;
        logic [DW-1:0]     num;
        logic [DATA_W-1:0] den;
        logic              neg;
    } lane_t;

    typedef struct packed {
        item_t item;
        lane_t lx;
        lane_t ly;
    } div_t;

    typedef struct packed {
        logic                     dz;
        logic                     ov;
        logic signed [DATA_W-1:0] rs;
        logic signed [DATA_W-1:0] ry;
        logic signed [DATA_W-1:0] rx;
    } out_t;

    typedef struct packed {
        logic                     ov;
        logic signed [DATA_W-1:0] val;
    } sat_t;

    // Clamp a wide signed value to the word range.
    function automatic sat_t sat_s(input logic signed [WIDE-1:0] v);
        sat_t r;
        r.ov  = 1'b0;
        r.val = v[DATA_W-1:0];
        if (v > SMAX_WIDE) begin
            r.ov  = 1'b1;
            r.val = SMAX;
        end else if (v < SMIN_WIDE) begin
            r.ov  = 1'b1;
            r.val = SMIN;
        end
        return r;
    endfunction

    // Clamp an unsigned value to the positive word range.
    function automatic sat_t sat_u(input logic [SQ_W-1:0] v);
        sat_t r;
        r.ov  = 1'b0;
        r.val = v[DATA_W-1:0];
        if (v > {{(SQ_W-DATA_W){1'b0}}, SMAX}) begin
            r.ov  = 1'b1;
            r.val = SMAX;
        end
        return r;
    endfunction

    // Magnitude of a signed word as an unsigned word.
    function automatic logic [DATA_W-1:0] abs_w(input logic signed [DATA_W-1:0] v);
        return v[DATA_W-1] ? DATA_W'(-v) : DATA_W'(v);
    endfunction

    // Saturated quotient for a zero divisor.
    function automatic logic signed [DATA_W-1:0] zero_div_val(
        input logic signed [DATA_W-1:0] a
    );
        logic signed [DATA_W-1:0] r;
        r = '0;
        if (a > 0) begin
            r = SMAX;
        end else if (a < 0) begin
            r = SMIN;
        end
        return r;
    endfunction

endpackage

>>> hdl/vadu_sqrt_cell.sv
// One digit cell of the integer square root chain.
module vadu_sqrt_cell (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                en,
    input  logic [vadu_pkg::BIT_POS_W-1:0]      bit_pos,
    input  logic                                in_valid,
    input  vadu_pkg::sqrt_t                     in_data,
    output logic                                out_valid,
    output vadu_pkg::sqrt_t                     out_data
);

    logic                          valid_reg;
    vadu_pkg::sqrt_t               data_reg;
    vadu_pkg::sqrt_t               data_next;
    logic [vadu_pkg::SQ_W-1:0]     pow_q;
    logic [vadu_pkg::SQ_W-1:0]     trial;

    // Try one root digit: subtract root plus digit weight where it fits.
    always_comb begin
        pow_q     = vadu_pkg::SQ_W'(1) << {bit_pos, 1'b0};
        trial     = in_data.root + pow_q;
        data_next = in_data;
        if (in_data.rem >= trial) begin
            data_next.rem  = in_data.rem - trial;
            data_next.root = (in_data.root >> 1) + pow_q;
        end else begin
            data_next.root = in_data.root >> 1;
        end
    end

    // Advance the request with the chain.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

>>> hdl/vadu_div_cell.sv
// One quotient-bit cell of the two-lane restoring divider chain.
module vadu_div_cell (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           en,
    input  logic           in_valid,
    input  vadu_pkg::div_t in_data,
    output logic           out_valid,
    output vadu_pkg::div_t out_data
);

    logic           valid_reg;
    vadu_pkg::div_t data_reg;
    vadu_pkg::div_t data_next;

    // Shift one dividend bit into the remainder and subtract where it fits.
    function automatic vadu_pkg::lane_t lane_step(input vadu_pkg::lane_t l);
        vadu_pkg::lane_t          r;
        logic [vadu_pkg::DATA_W:0] t;
        logic                      ge;
        r  = l;
        t  = {l.rem, l.num[vadu_pkg::DW-1]};
        ge = t >= {1'b0, l.den};
        r.rem = ge ? vadu_pkg::DATA_W'(t - {1'b0, l.den}) : t[vadu_pkg::DATA_W-1:0];
        r.num = {l.num[vadu_pkg::DW-2:0], ge};
        return r;
    endfunction

    always_comb begin
        data_next    = in_data;
        data_next.lx = lane_step(in_data.lx);
        data_next.ly = lane_step(in_data.ly);
    end

    // Advance the request with the chain.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

>>> hdl/vadu_front.sv
// Front stages: operand select, add and subtract, multipliers and squares.
module vadu_front (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            en,
    input  logic            in_valid,
    input  vadu_pkg::in_t   in_data,
    output logic            out_valid,
    output vadu_pkg::item_t out_data
);

    typedef struct packed {
        logic [3:0]                         act;
        logic signed [vadu_pkg::DATA_W-1:0] ax;
        logic signed [vadu_pkg::DATA_W-1:0] ay;
        logic signed [vadu_pkg::DATA_W-1:0] ox;
        logic signed [vadu_pkg::DATA_W-1:0] oy;
        logic signed [vadu_pkg::WIDE-1:0]   prod_x;
        logic signed [vadu_pkg::WIDE-1:0]   prod_y;
        logic signed [vadu_pkg::DATA_W-1:0] rxp;
        logic signed [vadu_pkg::DATA_W-1:0] ryp;
        logic                               ovp;
        logic                               dist_big;
    } s1_t;

    logic            v0_reg, v1_reg, v2_reg;
    vadu_pkg::in_t   r0_reg;
    s1_t             r1_reg, r1_next;
    vadu_pkg::item_t r2_reg, r2_next;

    logic signed [vadu_pkg::DATA_W-1:0] ox, oy;
    logic signed [vadu_pkg::DATA_W:0]   sum_x, sum_y, dx, dy;
    logic signed [vadu_pkg::DATA_W:0]   ma_x, mb_x, ma_y, mb_y;
    vadu_pkg::sat_t                     sat_x, sat_y, mq_x, mq_y, us;
    logic [vadu_pkg::SQ_W-1:0]          sq_sum;

    // Stage one: pick the second operand, add or subtract, multiply.
    always_comb begin
        if (r0_reg.act >= vadu_pkg::ACT_ADD_S && r0_reg.act <= vadu_pkg::ACT_DIV_S) begin
            ox = r0_reg.sc;
            oy = r0_reg.sc;
        end else begin
            ox = r0_reg.bx;
            oy = r0_reg.by;
        end
        case (r0_reg.act) inside
            vadu_pkg::ACT_ADD_V, vadu_pkg::ACT_ADD_S: begin
                sum_x = 33'(r0_reg.ax) + 33'(ox);
                sum_y = 33'(r0_reg.ay) + 33'(oy);
            end
            vadu_pkg::ACT_SUB_V, vadu_pkg::ACT_SUB_S: begin
                sum_x = 33'(r0_reg.ax) - 33'(ox);
                sum_y = 33'(r0_reg.ay) - 33'(oy);
            end
            default: begin
                sum_x = '0;
                sum_y = '0;
            end
        endcase
        sat_x = vadu_pkg::sat_s(vadu_pkg::WIDE'(sum_x));
        sat_y = vadu_pkg::sat_s(vadu_pkg::WIDE'(sum_y));
        dx    = 33'(r0_reg.ax) - 33'(r0_reg.bx);
        dy    = 33'(r0_reg.ay) - 33'(r0_reg.by);
        case (r0_reg.act) inside
            vadu_pkg::ACT_MUL_V, vadu_pkg::ACT_MUL_S: begin
                ma_x = 33'(r0_reg.ax);
                mb_x = 33'(ox);
                ma_y = 33'(r0_reg.ay);
                mb_y = 33'(oy);
            end
            vadu_pkg::ACT_SQDIST: begin
                ma_x = dx;
                mb_x = dx;
                ma_y = dy;
                mb_y = dy;
            end
            default: begin
                ma_x = 33'(r0_reg.ax);
                mb_x = 33'(r0_reg.ax);
                ma_y = 33'(r0_reg.ay);
                mb_y = 33'(r0_reg.ay);
            end
        endcase
        r1_next.act      = r0_reg.act;
        r1_next.ax       = r0_reg.ax;
        r1_next.ay       = r0_reg.ay;
        r1_next.ox       = ox;
        r1_next.oy       = oy;
        r1_next.prod_x   = ma_x * mb_x;
        r1_next.prod_y   = ma_y * mb_y;
        r1_next.rxp      = sat_x.val;
        r1_next.ryp      = sat_y.val;
        r1_next.ovp      = sat_x.ov | sat_y.ov;
        // a difference at or beyond 2^31 in magnitude saturates the distance
        r1_next.dist_big = (dx[vadu_pkg::DATA_W] != dx[vadu_pkg::DATA_W-1]) ||
                           (dx == {2'b11, {(vadu_pkg::DATA_W-1){1'b0}}}) ||
                           (dy[vadu_pkg::DATA_W] != dy[vadu_pkg::DATA_W-1]) ||
                           (dy == {2'b11, {(vadu_pkg::DATA_W-1){1'b0}}});
    end

    // Stage two: scale products, sum squares, pick early results.
    always_comb begin
        mq_x   = vadu_pkg::sat_s(r1_reg.prod_x >>> vadu_pkg::FRAC_BITS);
        mq_y   = vadu_pkg::sat_s(r1_reg.prod_y >>> vadu_pkg::FRAC_BITS);
        sq_sum = r1_reg.prod_x[vadu_pkg::SQ_W-1:0] + r1_reg.prod_y[vadu_pkg::SQ_W-1:0];
        us     = vadu_pkg::sat_u(sq_sum >> vadu_pkg::FRAC_BITS);
        r2_next.act = r1_reg.act;
        r2_next.ax  = r1_reg.ax;
        r2_next.ay  = r1_reg.ay;
        r2_next.ox  = r1_reg.ox;
        r2_next.oy  = r1_reg.oy;
        r2_next.sq  = sq_sum;
        r2_next.rx  = '0;
        r2_next.ry  = '0;
        r2_next.rs  = '0;
        r2_next.ov  = 1'b0;
        case (r1_reg.act) inside
            vadu_pkg::ACT_ADD_V, vadu_pkg::ACT_SUB_V,
            vadu_pkg::ACT_ADD_S, vadu_pkg::ACT_SUB_S: begin
                r2_next.rx = r1_reg.rxp;
                r2_next.ry = r1_reg.ryp;
                r2_next.ov = r1_reg.ovp;
            end
            vadu_pkg::ACT_MUL_V, vadu_pkg::ACT_MUL_S: begin
                r2_next.rx = mq_x.val;
                r2_next.ry = mq_y.val;
                r2_next.ov = mq_x.ov | mq_y.ov;
            end
            vadu_pkg::ACT_SQDIST: begin
                if (r1_reg.dist_big) begin
                    r2_next.rs = vadu_pkg::SMAX;
                    r2_next.ov = 1'b1;
                end else begin
                    r2_next.rs = us.val;
                    r2_next.ov = us.ov;
                end
            end
            vadu_pkg::ACT_SQMAG: begin
                r2_next.rs = us.val;
                r2_next.ov = us.ov;
            end
            default: begin
                r2_next.rs = '0;
            end
        endcase
    end

    // Advance the front stages together with the chain.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (en) begin
            v0_reg <= in_valid;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            r0_reg <= in_data;
            r1_reg <= r1_next;
            r2_reg <= r2_next;
        end
    end

    assign out_valid = v2_reg;
    assign out_data  = r2_reg;

endmodule

>>> hdl/vector2d_fixed_point_alu_core.sv
// Path from accept to m_tvalid (Q16.16 operands): three front stages, 32 square-root
// cells, 32 + FRAC_BITS divider cells, then the two-entry output buffer.
// Throughput: one request per cycle; the chain stalls only while the two-entry
// output buffer is full.
// Reset: aresetn low clears all stage valids and empties the output buffer.
`include "vector2d_fixed_point_alu_core_macros.svh"

// Top level of the 2D fixed-point vector ALU.
module vector2d_fixed_point_alu_core (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // a_x, a_y, b_x, b_y, scalar_in
    input  logic [159:0] s_tdata,
    // action
    input  logic [3:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // res_x, res_y, res_scalar, overflow, div_zero, zero fill
    output logic [103:0] m_tdata
);

    localparam int NS = vadu_pkg::ROOT_W;
    localparam int ND = vadu_pkg::DW;

    logic            pipe_en;
    vadu_pkg::in_t   s_item;
    logic            fr_valid;
    vadu_pkg::item_t fr_item;

    vadu_pkg::sqrt_t sq_data [NS+1];
    logic            sq_vld  [NS+1];
    vadu_pkg::div_t  dv_data [ND+1];
    logic            dv_vld  [ND+1];

    vadu_pkg::out_t  fin;
    vadu_pkg::out_t  fifo_reg [2];
    vadu_pkg::out_t  head;
    logic [1:0]      cnt_reg, cnt_next;
    logic            wr_ptr_reg, rd_ptr_reg;
    logic            push, pop;

    // Hold the chain only when the output buffer is full.
    assign pipe_en  = (cnt_reg != 2'd2);
    assign s_tready = pipe_en;

    always_comb begin
        s_item.act = s_tuser;
        s_item.ax  = s_tdata[31:0];
        s_item.ay  = s_tdata[63:32];
        s_item.bx  = s_tdata[95:64];
        s_item.by  = s_tdata[127:96];
        s_item.sc  = s_tdata[159:128];
    end

    vadu_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (pipe_en),
        .in_valid  (s_tvalid),
        .in_data   (s_item),
        .out_valid (fr_valid),
        .out_data  (fr_item)
    );

    // Seed the root chain with the sum of squares.
    always_comb begin
        sq_vld[0]       = fr_valid;
        sq_data[0].item = fr_item;
        sq_data[0].rem  = fr_item.sq;
        sq_data[0].root = '0;
    end

    for (genvar gi = 0; gi < NS; gi++) begin : g_sqrt
        vadu_sqrt_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (pipe_en),
            .bit_pos   (vadu_pkg::BIT_POS_W'(NS - 1 - gi)),
            .in_valid  (sq_vld[gi]),
            .in_data   (sq_data[gi]),
            .out_valid (sq_vld[gi+1]),
            .out_data  (sq_data[gi+1])
        );
    end

    // Set up divider lanes: operand divisor for divide, root for normalize.
    always_comb begin
        logic [vadu_pkg::ROOT_W-1:0] root;
        vadu_pkg::sat_t              ms;
        logic                        is_div;
        root   = sq_data[NS].root[vadu_pkg::ROOT_W-1:0];
        ms     = vadu_pkg::sat_u(vadu_pkg::SQ_W'(root));
        is_div = (sq_data[NS].item.act == vadu_pkg::ACT_DIV_V) ||
                 (sq_data[NS].item.act == vadu_pkg::ACT_DIV_S);
        dv_vld[0]       = sq_vld[NS];
        dv_data[0].item = sq_data[NS].item;
        if (sq_data[NS].item.act == vadu_pkg::ACT_MAG) begin
            dv_data[0].item.rs = ms.val;
            dv_data[0].item.ov = ms.ov;
        end
        dv_data[0].lx.rem = '0;
        dv_data[0].ly.rem = '0;
        dv_data[0].lx.num = {vadu_pkg::abs_w(sq_data[NS].item.ax),
                             {vadu_pkg::FRAC_BITS{1'b0}}};
        dv_data[0].ly.num = {vadu_pkg::abs_w(sq_data[NS].item.ay),
                             {vadu_pkg::FRAC_BITS{1'b0}}};
        if (is_div) begin
            dv_data[0].lx.den = vadu_pkg::abs_w(sq_data[NS].item.ox);
            dv_data[0].ly.den = vadu_pkg::abs_w(sq_data[NS].item.oy);
            dv_data[0].lx.neg = sq_data[NS].item.ax[vadu_pkg::DATA_W-1] ^
                                sq_data[NS].item.ox[vadu_pkg::DATA_W-1];
            dv_data[0].ly.neg = sq_data[NS].item.ay[vadu_pkg::DATA_W-1] ^
                                sq_data[NS].item.oy[vadu_pkg::DATA_W-1];
        end else begin
            dv_data[0].lx.den = vadu_pkg::DATA_W'(root);
            dv_data[0].ly.den = vadu_pkg::DATA_W'(root);
            dv_data[0].lx.neg = sq_data[NS].item.ax[vadu_pkg::DATA_W-1];
            dv_data[0].ly.neg = sq_data[NS].item.ay[vadu_pkg::DATA_W-1];
        end
    end

    for (genvar gj = 0; gj < ND; gj++) begin : g_div
        vadu_div_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (pipe_en),
            .in_valid  (dv_vld[gj]),
            .in_data   (dv_data[gj]),
            .out_valid (dv_vld[gj+1]),
            .out_data  (dv_data[gj+1])
        );
    end

    // Sign the quotients and finish divide and normalize results.
    always_comb begin
        logic signed [ND:0] qx, qy;
        vadu_pkg::sat_t     sx, sy;
        vadu_pkg::item_t    it;
        it = dv_data[ND].item;
        qx = dv_data[ND].lx.neg ? -$signed({1'b0, dv_data[ND].lx.num})
                                : $signed({1'b0, dv_data[ND].lx.num});
        qy = dv_data[ND].ly.neg ? -$signed({1'b0, dv_data[ND].ly.num})
                                : $signed({1'b0, dv_data[ND].ly.num});
        sx = vadu_pkg::sat_s(vadu_pkg::WIDE'(qx));
        sy = vadu_pkg::sat_s(vadu_pkg::WIDE'(qy));
        fin.rx = it.rx;
        fin.ry = it.ry;
        fin.rs = it.rs;
        fin.ov = it.ov;
        fin.dz = 1'b0;
        case (it.act) inside
            vadu_pkg::ACT_DIV_V, vadu_pkg::ACT_DIV_S: begin
                if (it.ox == '0) begin
                    fin.dz = 1'b1;
                    fin.rx = vadu_pkg::zero_div_val(it.ax);
                end else begin
                    fin.rx = sx.val;
                    fin.ov = fin.ov | sx.ov;
                end
                if (it.oy == '0) begin
                    fin.dz = 1'b1;
                    fin.ry = vadu_pkg::zero_div_val(it.ay);
                end else begin
                    fin.ry = sy.val;
                    fin.ov = fin.ov | sy.ov;
                end
            end
            vadu_pkg::ACT_NORM: begin
                // zero vector stays zero
                if (it.sq != '0) begin
                    fin.rx = qx[vadu_pkg::DATA_W-1:0];
                    fin.ry = qy[vadu_pkg::DATA_W-1:0];
                end
            end
            default: begin
                fin.dz = 1'b0;
            end
        endcase
    end

    // Output buffer: push from the chain end, pop on the master handshake.
    assign push = dv_vld[ND] && pipe_en;
    assign pop  = m_tvalid && m_tready;

    always_comb begin
        cnt_next = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + 2'd1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg    <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end else begin
            cnt_reg <= cnt_next;
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_reg[wr_ptr_reg] <= fin;
        end
    end

    assign head     = fifo_reg[rd_ptr_reg];
    assign m_tvalid = (cnt_reg != 2'd0);
    assign m_tdata  = {6'd0, head.dz, head.ov, head.rs, head.ry, head.rx};

    // Buffer never overfills and the count tracks push and pop.
    `VADU_ASSERT_NOW(a_no_overfill, aclk, aresetn, push, cnt_reg != 2'd2)
    `VADU_ASSERT_NEXT(a_cnt_drop, aclk, aresetn, pop && !push && cnt_reg == 2'd2, cnt_reg == 2'd1)
    // A result is either a vector or a scalar, never both.
    `VADU_ASSERT_NOW(a_vec_or_scalar, aclk, aresetn, m_tvalid, (head.rs == '0) || (head.rx == '0 && head.ry == '0))

endmodule

>>> tb/vector2d_fixed_point_alu_core_tb.sv
// Self-checking testbench for the 2D fixed-point vector ALU core.
module vector2d_fixed_point_alu_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 200;
    localparam int RANDOM_ITEMS   = 400;

    typedef struct packed {
        logic [3:0]               act;
        logic signed [31:0]       ax;
        logic signed [31:0]       ay;
        logic signed [31:0]       bx;
        logic signed [31:0]       by;
        logic signed [31:0]       sc;
    } vec_req_t;

    typedef struct packed {
        logic signed [31:0] rx;
        logic signed [31:0] ry;
        logic signed [31:0] rs;
        logic               ov;
        logic               dz;
    } vec_res_t;

    typedef struct {
        vec_req_t req;
        bit       fixed;
        vec_res_t res;
    } dir_row_t;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [159:0] s_tdata;
    logic [3:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [103:0] m_tdata;

    vec_res_t expected_q[$];
    int       fail_count;
    int       idle_cycles;
    bit       stim_done;

    vector2d_fixed_point_alu_core DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always begin
        aclk = 1'b1; #5;
        aclk = 1'b0; #5;
    end

    // Clamp a wide value to the signed word range
    function automatic logic signed [31:0] clamp_word(input longint v, inout bit ov);
        if (v > 64'sd2147483647) begin
            ov = 1; return 32'sh7FFFFFFF;
        end
        if (v < -64'sd2147483648) begin
            ov = 1; return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] fx_product(input longint a, input longint b,
                                                      inout bit ov);
        longint p;
        p = a * b;
        return clamp_word(p >>> vadu_pkg::FRAC_BITS, ov);
    endfunction

    function automatic logic signed [31:0] fx_quotient(input longint a, input longint b,
                                                       inout bit ov, inout bit dz);
        if (b == 0) begin
            dz = 1;
            return a > 0 ? 32'sh7FFFFFFF : (a < 0 ? 32'sh80000000 : 32'sh0);
        end
        return clamp_word((a * 65536) / b, ov);
    endfunction

    function automatic longint unsigned floor_root(input longint unsigned v);
        longint unsigned rem, root, bitv;
        rem = v; root = 0; bitv = 64'h4000000000000000;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (rem >= root + bitv) begin
                rem -= root + bitv;
                root = (root >> 1) + bitv;
            end else begin
                root >>= 1;
            end
            bitv >>= 2;
        end
        return root;
    endfunction

    function automatic logic signed [31:0] clamp_pos(input longint unsigned v, inout bit ov);
        if (v > 64'd2147483647) begin
            ov = 1; return 32'sh7FFFFFFF;
        end
        return v[31:0];
    endfunction

    // Compute the vector ALU result of one request
    function automatic vec_res_t vector_alu_result(input vec_req_t q);
        vec_res_t r;
        bit ov, dz;
        longint ax, ay, ox, oy, m;
        longint unsigned dx, dy, sq;
        r = '0; ov = 0; dz = 0;
        ax = q.ax; ay = q.ay; ox = q.bx; oy = q.by;
        if (q.act >= vadu_pkg::ACT_ADD_S && q.act <= vadu_pkg::ACT_DIV_S) begin
            ox = q.sc; oy = q.sc;
        end
        case (q.act)
            vadu_pkg::ACT_ADD_V, vadu_pkg::ACT_ADD_S: begin
                r.rx = clamp_word(ax + ox, ov); r.ry = clamp_word(ay + oy, ov);
            end
            vadu_pkg::ACT_SUB_V, vadu_pkg::ACT_SUB_S: begin
                r.rx = clamp_word(ax - ox, ov); r.ry = clamp_word(ay - oy, ov);
            end
            vadu_pkg::ACT_MUL_V, vadu_pkg::ACT_MUL_S: begin
                r.rx = fx_product(ax, ox, ov); r.ry = fx_product(ay, oy, ov);
            end
            vadu_pkg::ACT_DIV_V, vadu_pkg::ACT_DIV_S: begin
                r.rx = fx_quotient(ax, ox, ov, dz); r.ry = fx_quotient(ay, oy, ov, dz);
            end
            vadu_pkg::ACT_SQDIST: begin
                dx = (ax - q.bx) < 0 ? -(ax - q.bx) : (ax - q.bx);
                dy = (ay - q.by) < 0 ? -(ay - q.by) : (ay - q.by);
                if (dx >= 64'h80000000 || dy >= 64'h80000000) begin
                    ov = 1; r.rs = 32'sh7FFFFFFF;
                end else begin
                    r.rs = clamp_pos((dx * dx + dy * dy) >> vadu_pkg::FRAC_BITS, ov);
                end
            end
            vadu_pkg::ACT_MAG, vadu_pkg::ACT_SQMAG, vadu_pkg::ACT_NORM: begin
                dx = ax < 0 ? -ax : ax;
                dy = ay < 0 ? -ay : ay;
                sq = dx * dx + dy * dy;
                if (q.act == vadu_pkg::ACT_MAG) begin
                    r.rs = clamp_pos(floor_root(sq), ov);
                end else if (q.act == vadu_pkg::ACT_SQMAG) begin
                    r.rs = clamp_pos(sq >> vadu_pkg::FRAC_BITS, ov);
                end else if (sq != 0) begin
                    m = floor_root(sq);
                    r.rx = 32'((ax * 65536) / m);
                    r.ry = 32'((ay * 65536) / m);
                end
            end
            default: ;
        endcase
        r.ov = ov; r.dz = dz;
        return r;
    endfunction

    function automatic logic [31:0] rand_operand();
        case ($urandom_range(0, 7))
            0: return 32'h7FFFFFFF;
            1: return 32'h80000000;
            2: return '0;
            3: return 32'($urandom_range(0, 8)) << 16;
            4: return -(32'($urandom_range(0, 8)) << 16);
            5: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
            default: return $urandom;
        endcase
    endfunction

    // Send one request, recording its expected result
    task automatic send_request(input vec_req_t q, input vec_res_t exp_res, input bit fixed);
        s_tvalid <= 1'b1;
        s_tdata  <= {q.sc, q.by, q.bx, q.ay, q.ax};
        s_tuser  <= q.act;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        expected_q.push_back(fixed ? exp_res : vector_alu_result(q));
    endtask

    task automatic sender_gap();
        if ($urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
    endtask

    // Stall the receiver on its own pattern
    initial begin
        int phase;
        m_tready <= 1'b0;
        phase = 0;
        forever begin
            @(posedge aclk);
            phase++;
            if (phase < 300) m_tready <= 1'b1;
            else if (phase % 200 < 100) m_tready <= (phase % 7) != 0;
            else m_tready <= $urandom_range(0, 2) != 0;
        end
    end

    // Compare each accepted result with the oldest expectation
    always @(posedge aclk) begin
        vec_res_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got.rx = m_tdata[31:0];
            got.ry = m_tdata[63:32];
            got.rs = m_tdata[95:64];
            got.ov = m_tdata[96];
            got.dz = m_tdata[97];
            if (expected_q.size() == 0) begin
                $error("result with no request pending: %h", got);
                fail_count++;
            end else begin
                want = expected_q.pop_front();
                if (got.rx != want.rx) begin
                    $error("res_x expected %h got %h", want.rx, got.rx); fail_count++;
                end
                if (got.ry != want.ry) begin
                    $error("res_y expected %h got %h", want.ry, got.ry); fail_count++;
                end
                if (got.rs != want.rs) begin
                    $error("res_scalar expected %h got %h", want.rs, got.rs); fail_count++;
                end
                if (got.ov != want.ov) begin
                    $error("overflow expected %b got %b", want.ov, got.ov); fail_count++;
                end
                if (got.dz != want.dz) begin
                    $error("div_zero expected %b got %b", want.dz, got.dz); fail_count++;
                end
            end
        end
    end

    // Watchdog on cycles with no handshake
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (stim_done && expected_q.size() == 0)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        dir_row_t rows[$];
        dir_row_t row;
        vec_req_t q;
        int k;
        fail_count  = 0;
        idle_cycles = 0;
        stim_done   = 0;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed table; fixed rows carry an obvious result
        rows.push_back('{'{vadu_pkg::ACT_ADD_V, 32'h7FFFFFFF, 32'h80000000, 32'h1,
                           32'hFFFFFFFF, 0}, 1,
                         '{32'h7FFFFFFF, 32'h80000000, 0, 1, 0}});
        rows.push_back('{'{vadu_pkg::ACT_SUB_V, 32'h80000000, 32'h7FFFFFFF, 32'h1,
                           32'hFFFFFFFF, 0}, 1,
                         '{32'h80000000, 32'h7FFFFFFF, 0, 1, 0}});
        rows.push_back('{'{vadu_pkg::ACT_DIV_V, 32'h10000, 32'hFFFF0000, 0, 0, 0}, 1,
                         '{32'h7FFFFFFF, 32'h80000000, 0, 0, 1}});
        rows.push_back('{'{vadu_pkg::ACT_DIV_S, 0, 32'h5, 0, 0, 0}, 1,
                         '{0, 32'h7FFFFFFF, 0, 0, 1}});
        rows.push_back('{'{vadu_pkg::ACT_NORM, 0, 0, 32'h5, 32'h5, 32'h5}, 1,
                         '{0, 0, 0, 0, 0}});
        rows.push_back('{'{4'd12, 32'h10000, 32'h10000, 32'h10000, 32'h10000, 32'h10000}, 1,
                         '{0, 0, 0, 0, 0}});
        rows.push_back('{'{4'd15, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
                           32'hFFFFFFFF}, 1, '{0, 0, 0, 0, 0}});
        rows.push_back('{'{vadu_pkg::ACT_SQDIST, 32'h7FFFFFFF, 0, 32'h80000000, 0, 0}, 1,
                         '{0, 0, 32'h7FFFFFFF, 1, 0}});
        rows.push_back('{'{vadu_pkg::ACT_MUL_V, 32'h20000, 32'hFFFFFFFF, 32'h30000, 32'h1, 0},
                         0, '0});
        rows.push_back('{'{vadu_pkg::ACT_MUL_S, 32'h7FFFFFFF, 32'h80000000, 0, 0,
                           32'h7FFFFFFF}, 0, '0});
        rows.push_back('{'{vadu_pkg::ACT_ADD_S, 32'h10000, 32'h7FFFFFFF, 0, 0, 32'h1}, 0, '0});
        rows.push_back('{'{vadu_pkg::ACT_SUB_S, 32'h10000, 32'h80000000, 0, 0, 32'h1}, 0, '0});
        rows.push_back('{'{vadu_pkg::ACT_DIV_V, 32'h7FFFFFFF, 32'h80000000, 32'h1,
                           32'hFFFFFFFF, 0}, 0, '0});
        rows.push_back('{'{vadu_pkg::ACT_DIV_S, 32'h30000, 32'hFFFD0000, 0, 0, 32'h20000},
                         0, '0});
        rows.push_back('{'{vadu_pkg::ACT_SQDIST, 32'h30000, 32'h40000, 0, 0, 0}, 0, '0});
        rows.push_back('{'{vadu_pkg::ACT_MAG, 32'h80000000, 32'h80000000, 0, 0, 0}, 0, '0});
        rows.push_back('{'{vadu_pkg::ACT_MAG, 32'h30000, 32'h40000, 0, 0, 0}, 0, '0});
        rows.push_back('{'{vadu_pkg::ACT_SQMAG, 32'h80000000, 32'h7FFFFFFF, 0, 0, 0}, 0, '0});
        rows.push_back('{'{vadu_pkg::ACT_SQMAG, 32'h20000, 32'hFFFF0000, 0, 0, 0}, 0, '0});
        rows.push_back('{'{vadu_pkg::ACT_NORM, 32'h80000000, 32'h7FFFFFFF, 0, 0, 0}, 0, '0});
        rows.push_back('{'{vadu_pkg::ACT_NORM, 32'h1, 0, 0, 0, 0}, 0, '0});
        foreach (rows[i]) begin
            send_request(rows[i].req, rows[i].res, rows[i].fixed);
            if (i > 8) sender_gap();
        end

        // Random requests in bursts with gaps
        k = 0;
        while (k < RANDOM_ITEMS) begin
            repeat ($urandom_range(1, 20)) begin
                q.act = $urandom_range(0, 15) < 14 ? 4'($urandom_range(0, 11))
                                                  : 4'($urandom_range(12, 15));
                q.ax = rand_operand(); q.ay = rand_operand();
                q.bx = rand_operand(); q.by = rand_operand();
                q.sc = rand_operand();
                send_request(q, '0, 0);
                k++;
            end
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
        stim_done = 1;

        while (expected_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
